FILE: src/skr_pkg.sv
// shared types and constants for the streaming k-th smallest selector
package skr_pkg;

  localparam int SAMPLE_W     = 32;
  localparam int RANK_W       = 5;
  localparam int MAX_RANK_DEF = 16;

  localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(1);

  typedef struct packed {
    logic                       last;
    logic signed [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic                       too_few;
    logic signed [SAMPLE_W-1:0] kth_value;
  } result_t;

endpackage

FILE: src/streaming_kth_smallest.sv
// top level of the streaming k-th smallest selector
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------
//  input    | s_tvalid / s_tready          | s_tdata = sample, s_tlast = last
//  output   | m_tvalid / m_tready          | m_tdata = kth_value, m_tuser = too_few
//  rank cfg | cfg_valid / cfg_ready        | cfg_data = rank
//
// one item per cycle unless stalled; the result register loads as a last item is taken
// the update compares the item against all kept entries at once
// reset sets rank to 1 and the count to zero; kept entries are not cleared
// when m_tready is low the result holds, the input register fills and s_tready drops
module streaming_kth_smallest #(
  parameter int MAX_RANK = skr_pkg::MAX_RANK_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [skr_pkg::SAMPLE_W-1:0] s_tdata,   // [31:0] sample
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [skr_pkg::SAMPLE_W-1:0] m_tdata,   // [31:0] kth_value
  output logic                         m_tuser,   // [0] too_few
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [skr_pkg::RANK_W-1:0]   cfg_data
);
  import skr_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    take;
  logic    out_free;
  logic    res_load;
  result_t result;
  result_t res_out;

  assign in_item.sample = s_tdata;
  assign in_item.last   = s_tlast;

  assign take      = held_valid && out_free;
  assign cfg_ready = 1'b1;

  skr_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .take      (take),
    .held_valid(held_valid),
    .held_item (held_item)
  );

  skr_core #(
    .MAX_RANK(MAX_RANK)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .go       (take),
    .item     (held_item),
    .res_load (res_load),
    .result   (result)
  );

  skr_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .load     (res_load),
    .res_in   (result),
    .free     (out_free),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .res_out  (res_out)
  );

  assign m_tdata = res_out.kth_value;
  assign m_tuser = res_out.too_few;

endmodule

FILE: src/skr_in_stage.sv
// input register stage holding one accepted item
module skr_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  skr_pkg::item_t in_item,
  input  logic           take,
  output logic           held_valid,
  output skr_pkg::item_t held_item
);
  import skr_pkg::*;

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

FILE: src/skr_sort_net.sv
// parallel insertion network: places one value into the sorted prefix of the kept entries
module skr_sort_net #(
  parameter int MAX_RANK = skr_pkg::MAX_RANK_DEF
) (
  input  logic signed [MAX_RANK-1:0][skr_pkg::SAMPLE_W-1:0] kept,
  input  logic signed [skr_pkg::SAMPLE_W-1:0]               value,
  input  logic [$clog2(MAX_RANK+1)-1:0]                     fill,
  input  logic                                              ins,
  output logic signed [MAX_RANK-1:0][skr_pkg::SAMPLE_W-1:0] kept_next
);
  import skr_pkg::*;

  localparam int CW = $clog2(MAX_RANK + 1);

  logic [MAX_RANK-1:0] gt;
  logic [MAX_RANK-1:0] below;

  genvar i;
  generate
    for (i = 0; i < MAX_RANK; i++) begin : g_lane
      // only entries under the fill point take part
      assign below[i] = CW'(i) < fill;
      // an element select of a packed array is unsigned, compare as signed
      assign gt[i]    = below[i] && ($signed(kept[i]) > value);

      if (i == 0) begin : g_first
        always_comb begin
          kept_next[i] = kept[i];
          if (ins && (gt[i] || CW'(i) == fill)) begin
            kept_next[i] = value;
          end
        end
      end else begin : g_rest
        always_comb begin
          kept_next[i] = kept[i];
          if (ins && (gt[i] || CW'(i) == fill)) begin
            // larger entries move up one place, the new value lands at the boundary
            kept_next[i] = gt[i-1] ? kept[i-1] : value;
          end
        end
      end
    end
  endgenerate

endmodule

FILE: src/skr_core.sv
// kept entries, count and rank register, with the per-item update and result decision
module skr_core #(
  parameter int MAX_RANK = skr_pkg::MAX_RANK_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [skr_pkg::RANK_W-1:0]   cfg_data,
  input  logic                         go,
  input  skr_pkg::item_t               item,
  output logic                         res_load,
  output skr_pkg::result_t             result
);
  import skr_pkg::*;

  localparam int CW = $clog2(MAX_RANK + 1);
  localparam int IW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int EW = (CW > RANK_W) ? CW : RANK_W;

  logic [RANK_W-1:0] rank;
  logic [CW-1:0]     seen;
  logic [CW-1:0]     seen_next;
  logic signed [MAX_RANK-1:0][SAMPLE_W-1:0] kept;
  logic signed [MAX_RANK-1:0][SAMPLE_W-1:0] kept_next;

  logic [EW-1:0] rank_ext;
  logic [CW-1:0] k;
  logic [IW-1:0] kidx;
  logic          filling;
  logic          ins;
  logic [CW-1:0] fill;

  // rank zero acts as one, large ranks clamp to the depth
  always_comb begin
    rank_ext = EW'(rank);
    if (rank_ext == '0) begin
      k = CW'(1);
    end else if (rank_ext > EW'(MAX_RANK)) begin
      k = CW'(MAX_RANK);
    end else begin
      k = CW'(rank_ext);
    end
  end

  assign kidx    = IW'(k - CW'(1));
  assign filling = seen < k;
  assign ins     = filling || (item.sample < $signed(kept[kidx]));
  assign fill    = filling ? seen : (k - CW'(1));

  skr_sort_net #(
    .MAX_RANK(MAX_RANK)
  ) u_sort_net (
    .kept     (kept),
    .value    (item.sample),
    .fill     (fill),
    .ins      (ins),
    .kept_next(kept_next)
  );

  assign seen_next = filling ? (seen + CW'(1)) : seen;

  assign res_load = go && item.last;

  always_comb begin
    result.too_few   = seen_next < k;
    result.kth_value = result.too_few ? '0 : kept_next[kidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank <= RANK_RESET;
      seen <= '0;
    end else begin
      if (cfg_valid) begin
        rank <= cfg_data;
      end
      if (go) begin
        seen <= item.last ? '0 : seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      kept <= kept_next;
    end
  end

endmodule

FILE: src/skr_out_stage.sv
// result register toward the output stream
module skr_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  skr_pkg::result_t res_in,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output skr_pkg::result_t res_out
);
  import skr_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule
